### src/set_assoc_cache_controller_defines.svh
// Assertion macros used by the cache controller RTL.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH
`define SET_ASSOC_CACHE_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SACC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define SACC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### src/sacc_pkg.sv
// Constants, codes, helper functions and control structs of the cache controller.
// No dependencies; the datapath, controller, top level and bench import this package.
`default_nettype none
package sacc_pkg;
	localparam int WAYS        = 4;
	localparam int SETS        = 64;
	localparam int BLOCK_WORDS = 8;

	localparam int WAY_W   = $clog2(WAYS);
	localparam int SET_W   = $clog2(SETS);
	localparam int WORD_W  = $clog2(BLOCK_WORDS);
	localparam int OFF_W   = WORD_W + 2;
	localparam int TAG_W   = 32 - OFF_W - SET_W;
	localparam int LINES   = SETS * WAYS;
	localparam int LINE_W  = SET_W + WAY_W;
	localparam int DADDR_W = LINE_W + WORD_W;
	localparam int DWORDS  = LINES * BLOCK_WORDS;
	localparam int AGE_W   = 16;
	localparam int META_W  = WAYS * AGE_W + WAY_W;
	localparam int TROW_W  = WAYS * TAG_W;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WB_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WR_ALLOC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPL     = 2'd2;

	typedef enum logic [2:0] {
		KIND_READ  = 3'd0,
		KIND_WDONE = 3'd1,
		KIND_FETCH = 3'd2,
		KIND_WBACK = 3'd3,
		KIND_WTHRU = 3'd4,
		KIND_BUSY  = 3'd5
	} kind_t;

	typedef struct packed {
		logic  latch_req;
		logic  load_acc;
		logic  fill_wr;
		logic  rd_rows;
		logic  cap_rows;
		logic  tag_upd;
		logic  hit_upd;
		logic  victim_upd;
		logic  wb_rd;
		logic  wb_step;
		logic  set_busy;
		logic  data_rd;
		logic  data_wr;
		logic  touch;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic       hit;
		logic       is_write;
		logic       alloc;
		logic       evict;
		logic       fill_last;
		logic       wb_last;
		logic       wt_differ;
		logic [1:0] op;
		logic       out_free;
	} sts_t;

	function automatic logic [31:0] size_mask(input logic [1:0] sz);
		return (sz == SZ_BYTE) ? 32'h0000_00FF :
		       (sz == SZ_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
	endfunction

	function automatic logic [31:0] align_addr(input logic [31:0] a, input logic [1:0] sz);
		return (sz == SZ_WORD) ? {a[31:2], 2'b00} :
		       (sz == SZ_HALF) ? {a[31:1], 1'b0} : a;
	endfunction
endpackage
`default_nettype wire

### src/sacc_ifs.sv
// Valid/ready channel interfaces: request beats in, result beats out.
// Standalone; widths follow the field list of the block.
`default_nettype none
interface sacc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] address;
	logic [1:0]  access_size;
	logic [31:0] write_data;
	logic [31:0] fill_data;
	modport source (output valid, op, address, access_size, write_data, fill_data,
		input ready);
	modport sink (input valid, op, address, access_size, write_data, fill_data,
		output ready);
endinterface

interface sacc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] out_address;
	logic [31:0] out_data;
	logic [1:0]  out_size;
	logic        was_hit;
	logic        last;
	modport source (output valid, kind, out_address, out_data, out_size, was_hit, last,
		input ready);
	modport sink (input valid, kind, out_address, out_data, out_size, was_hit, last,
		output ready);
endinterface
`default_nettype wire

### src/sacc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### src/sacc_datapath.sv
// Datapath: config registers, pending access, tag/meta/line RAMs, valid and dirty
// flags, result register. Depends on sacc_pkg, sacc_ifs and sacc_ram.
`default_nettype none
module sacc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [0:0]                       cfg_data,
	sacc_req_if.sink                         req,
	sacc_rsp_if.source                       rsp,
	input  sacc_pkg::cmd_t                   cmd,
	output sacc_pkg::sts_t                   sts
);
	import sacc_pkg::*;

	logic wb_mode_q, alloc_q, repl_q;
	logic [1:0]  req_op_q, req_size_q;
	logic [31:0] req_addr_q, req_wdata_q, req_fill_q;
	logic [31:0] acc_addr_q, acc_data_q;
	logic [1:0]  acc_size_q;
	logic        acc_write_q, acc_hit_q, busy_q;
	logic [WAY_W-1:0]  acc_way_q;
	logic [WORD_W-1:0] fcnt_q, wcnt_q;
	logic [LINES-1:0]  valid_q, dirty_q;
	logic [SETS-1:0]   mvld_q;
	logic [TROW_W-1:0] trow_q, trow_rd, trow_wr;
	logic [META_W-1:0] mrow_q, mrow_rd, mrow_wr, mrow_touch, mrow_vict;
	logic [31:0] drd, dwr, lane_old, merged, mask, req_dm;
	logic [DADDR_W-1:0] daddr;
	logic dwe, dre, meta_we;
	logic [SET_W-1:0]  set_idx;
	logic [TAG_W-1:0]  tag, vict_tag;
	logic [WORD_W-1:0] word;
	logic [LINE_W-1:0] acc_line, vict_line;
	logic [4:0] sh;
	logic [1:0] req_sz_n;
	logic hit;
	logic [WAY_W-1:0] hway, vway, rr;
	logic [AGE_W-1:0] best, age;
	logic ov_q;
	logic [2:0]  kind_q;
	logic [31:0] oaddr_q, odata_q;
	logic [1:0]  osize_q;
	logic        ohit_q, olast_q;

	assign set_idx   = acc_addr_q[OFF_W +: SET_W];
	assign tag       = acc_addr_q[31 -: TAG_W];
	assign word      = acc_addr_q[2 +: WORD_W];
	assign acc_line  = {set_idx, acc_way_q};
	assign vict_tag  = trow_q[acc_way_q*TAG_W +: TAG_W];
	assign sh        = {acc_addr_q[1:0], 3'b000};
	assign mask      = size_mask(acc_size_q);
	assign lane_old  = (drd >> sh) & mask;
	assign merged    = (drd & ~(mask << sh)) | ((acc_data_q << sh) & (mask << sh));
	assign req_sz_n  = (req_size_q > SZ_WORD) ? SZ_WORD : req_size_q;
	assign req_dm    = req_wdata_q & size_mask(req_sz_n);
	assign rr        = mrow_q[WAYS*AGE_W +: WAY_W];

	// tag compare over the captured set row
	always_comb begin
		hit  = 1'b0;
		hway = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (valid_q[{set_idx, WAY_W'(w)}] && trow_q[w*TAG_W +: TAG_W] == tag) begin
				hit  = 1'b1;
				hway = WAY_W'(w);
			end
		end
	end

	// victim: first oldest nonzero age, else keep pointer; round-robin steps on
	always_comb begin
		vway = rr;
		best = '0;
		age  = '0;
		if (repl_q) begin
			vway = (rr == WAY_W'(WAYS - 1)) ? '0 : rr + 1'b1;
		end else begin
			for (int w = 0; w < WAYS; w++) begin
				age = mrow_q[w*AGE_W +: AGE_W];
				if (age > best) begin
					best = age;
					vway = WAY_W'(w);
				end
			end
		end
	end

	assign vict_line = {set_idx, vway};

	always_comb begin
		mrow_vict = mrow_q;
		mrow_vict[WAYS*AGE_W +: WAY_W] = vway;
		mrow_touch = mrow_q;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == acc_way_q) begin
				mrow_touch[w*AGE_W +: AGE_W] = '0;
			end else if (mrow_q[w*AGE_W +: AGE_W] != AGE_MAX) begin
				mrow_touch[w*AGE_W +: AGE_W] = mrow_q[w*AGE_W +: AGE_W] + 1'b1;
			end
		end
		trow_wr = trow_q;
		trow_wr[acc_way_q*TAG_W +: TAG_W] = tag;
	end

	assign meta_we = cmd.touch | cmd.victim_upd;
	assign mrow_wr = cmd.victim_upd ? mrow_vict : mrow_touch;

	always_comb begin
		priority if (cmd.fill_wr) begin
			daddr = {acc_line, fcnt_q};
		end else if (cmd.wb_rd) begin
			daddr = {acc_line, wcnt_q};
		end else begin
			daddr = {acc_line, word};
		end
	end
	assign dwe = cmd.fill_wr | cmd.data_wr;
	assign dre = cmd.data_rd | cmd.wb_rd;
	assign dwr = cmd.fill_wr ? req_fill_q : merged;

	sacc_ram #(.WIDTH(TROW_W), .DEPTH(SETS)) u_tag_ram (
		.clk(clk), .we(cmd.tag_upd), .re(cmd.rd_rows), .addr(set_idx),
		.wdata(trow_wr), .rdata(trow_rd));

	sacc_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
		.clk(clk), .we(meta_we), .re(cmd.rd_rows), .addr(set_idx),
		.wdata(mrow_wr), .rdata(mrow_rd));

	sacc_ram #(.WIDTH(32), .DEPTH(DWORDS)) u_line_ram (
		.clk(clk), .we(dwe), .re(dre), .addr(daddr), .wdata(dwr), .rdata(drd));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_mode_q <= 1'b1;
			alloc_q   <= 1'b1;
			repl_q    <= 1'b0;
			busy_q    <= 1'b0;
			fcnt_q    <= '0;
			wcnt_q    <= '0;
			valid_q   <= '0;
			dirty_q   <= '0;
			mvld_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WB_MODE:  wb_mode_q <= cfg_data[0];
					REG_WR_ALLOC: alloc_q   <= cfg_data[0];
					REG_REPL:     repl_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.set_busy) begin
				busy_q <= 1'b1;
				fcnt_q <= '0;
			end
			if (cmd.fill_wr) begin
				if (fcnt_q == WORD_W'(BLOCK_WORDS - 1)) begin
					fcnt_q <= '0;
					busy_q <= 1'b0;
				end else begin
					fcnt_q <= fcnt_q + 1'b1;
				end
			end
			if (cmd.victim_upd) begin
				wcnt_q <= '0;
				// drop the dirty mark; the words go out next
				if (wb_mode_q && valid_q[vict_line] && dirty_q[vict_line]) begin
					dirty_q[vict_line] <= 1'b0;
				end
			end
			if (cmd.wb_step) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (cmd.tag_upd) begin
				valid_q[acc_line] <= 1'b1;
				dirty_q[acc_line] <= 1'b0;
			end
			if (cmd.data_wr && wb_mode_q) begin
				dirty_q[acc_line] <= 1'b1;
			end
			if (meta_we) begin
				mvld_q[set_idx] <= 1'b1;
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_op_q    <= req.op;
			req_addr_q  <= req.address;
			req_size_q  <= req.access_size;
			req_wdata_q <= req.write_data;
			req_fill_q  <= req.fill_data;
		end
		if (cmd.load_acc) begin
			acc_addr_q  <= align_addr(req_addr_q, req_sz_n);
			acc_size_q  <= req_sz_n;
			acc_data_q  <= req_dm;
			acc_write_q <= (req_op_q == OP_WRITE);
			acc_hit_q   <= 1'b0;
		end
		if (cmd.cap_rows) begin
			trow_q <= trow_rd;
			mrow_q <= mvld_q[set_idx] ? mrow_rd : '0;
		end
		if (cmd.hit_upd) begin
			acc_way_q <= hway;
			acc_hit_q <= 1'b1;
		end
		if (cmd.victim_upd) begin
			acc_way_q <= vway;
			mrow_q    <= mrow_vict;
		end
		if (cmd.emit) begin
			kind_q  <= cmd.emit_kind;
			olast_q <= cmd.emit_last;
			unique case (cmd.emit_kind)
				KIND_READ: begin
					oaddr_q <= acc_addr_q;
					odata_q <= lane_old;
					osize_q <= acc_size_q;
					ohit_q  <= acc_hit_q;
				end
				KIND_WDONE, KIND_WTHRU: begin
					oaddr_q <= acc_addr_q;
					odata_q <= acc_data_q;
					osize_q <= acc_size_q;
					ohit_q  <= acc_hit_q;
				end
				KIND_FETCH: begin
					oaddr_q <= {acc_addr_q[31:OFF_W], {OFF_W{1'b0}}};
					odata_q <= '0;
					osize_q <= SZ_BYTE;
					ohit_q  <= 1'b0;
				end
				KIND_WBACK: begin
					oaddr_q <= {vict_tag, set_idx, wcnt_q, 2'b00};
					odata_q <= drd;
					osize_q <= SZ_WORD;
					ohit_q  <= 1'b0;
				end
				default: begin
					oaddr_q <= '0;
					odata_q <= '0;
					osize_q <= SZ_BYTE;
					ohit_q  <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.kind        = kind_q;
	assign rsp.out_address = oaddr_q;
	assign rsp.out_data    = odata_q;
	assign rsp.out_size    = osize_q;
	assign rsp.was_hit     = ohit_q;
	assign rsp.last        = olast_q;

	assign sts.busy      = busy_q;
	assign sts.hit       = hit;
	assign sts.is_write  = acc_write_q;
	assign sts.alloc     = alloc_q;
	assign sts.evict     = wb_mode_q & valid_q[vict_line] & dirty_q[vict_line];
	assign sts.fill_last = (fcnt_q == WORD_W'(BLOCK_WORDS - 1));
	assign sts.wb_last   = (wcnt_q == WORD_W'(BLOCK_WORDS - 1));
	assign sts.wt_differ = !wb_mode_q && (acc_data_q != lane_old);
	assign sts.op        = req_op_q;
	assign sts.out_free  = !ov_q || rsp.ready;
endmodule
`default_nettype wire

### src/sacc_ctrl.sv
// Controller state machine: sequences lookup, writeback, fetch, fill, finish, busy reject and write-around.
// Depends on sacc_pkg and the assertion macro header.
`default_nettype none
`include "set_assoc_cache_controller_defines.svh"
module sacc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  sacc_pkg::sts_t sts,
	output sacc_pkg::cmd_t cmd
);
	import sacc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DEC   = 16'h0002,
		S_REJ   = 16'h0004,
		S_FILL  = 16'h0008,
		S_RD    = 16'h0010,
		S_CAP   = 16'h0020,
		S_CHK   = 16'h0040,
		S_FUPD  = 16'h0080,
		S_WA1   = 16'h0100,
		S_WA2   = 16'h0200,
		S_WBRD  = 16'h0400,
		S_WBOUT = 16'h0800,
		S_FETCH = 16'h1000,
		S_DRD   = 16'h2000,
		S_FIN   = 16'h4000,
		S_WDONE = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   fill_q, fill_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		cmd     = '0;
		cmd.emit_kind = KIND_READ;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_req = req_valid;
				if (req_valid) state_d = S_DEC;
			end
			S_DEC: begin
				priority if (sts.op == OP_NONE) begin
					state_d = S_IDLE;
				end else if (sts.op == OP_FILL) begin
					state_d = sts.busy ? S_FILL : S_IDLE;
				end else if (sts.busy) begin
					state_d = S_REJ;
				end else begin
					cmd.load_acc = 1'b1;
					fill_d  = 1'b0;
					state_d = S_RD;
				end
			end
			S_REJ: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_BUSY;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.fill_last) begin
					fill_d  = 1'b1;
					state_d = S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				cmd.rd_rows = 1'b1;
				state_d = S_CAP;
			end
			S_CAP: begin
				cmd.cap_rows = 1'b1;
				state_d = fill_q ? S_FUPD : S_CHK;
			end
			S_CHK: begin
				priority if (sts.hit) begin
					cmd.hit_upd = 1'b1;
					state_d = S_DRD;
				end else if (sts.is_write && !sts.alloc) begin
					state_d = S_WA1;
				end else begin
					cmd.victim_upd = 1'b1;
					state_d = sts.evict ? S_WBRD : S_FETCH;
				end
			end
			S_FUPD: begin
				cmd.tag_upd = 1'b1;
				state_d = S_DRD;
			end
			S_WA1: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_WTHRU;
					state_d = S_WA2;
				end
			end
			S_WA2: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_WDONE;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WBRD: begin
				cmd.wb_rd = 1'b1;
				state_d = S_WBOUT;
			end
			S_WBOUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_WBACK;
					cmd.wb_step = 1'b1;
					state_d = sts.wb_last ? S_FETCH : S_WBRD;
				end
			end
			S_FETCH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_FETCH;
					cmd.emit_last = 1'b1;
					cmd.set_busy = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DRD: begin
				cmd.data_rd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.touch = 1'b1;
					if (!sts.is_write) begin
						cmd.emit = 1'b1;
						cmd.emit_kind = KIND_READ;
						cmd.emit_last = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.data_wr = 1'b1;
						// forward only in write-through mode and when the stored lanes change
						cmd.emit = sts.wt_differ;
						cmd.emit_kind = KIND_WTHRU;
						state_d = S_WDONE;
					end
				end
			end
			S_WDONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = KIND_WDONE;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	`SACC_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
	`SACC_ASSERT_IMP(a_fill_pending, cmd.fill_wr, sts.busy)
	`SACC_ASSERT_NXT(a_fetch_pends, cmd.set_busy, sts.busy)
	`SACC_ASSERT_IMP(a_touch_idle_free, cmd.touch && cmd.victim_upd, 1'b0)
endmodule
`default_nettype wire

### src/set_assoc_cache_controller.sv
// Top level of the set-associative cache controller.
// Depends on sacc_pkg, sacc_ifs, sacc_ctrl and sacc_datapath.
//
// Usage:
//   req carries reads, writes and block-fill words (op, address, access_size,
//   write_data, fill_data); rsp carries result beats, the final one of each
//   request marked by last. Config is written through cfg_we/cfg_index/cfg_data
//   while no request is in flight.
//   One request is worked on at a time. A hit passes decode, set-row read, row
//   capture, tag check and line-word read before its finish gives the result
//   beat; a write may also forward a write-through beat. A miss first writes back
//   a dirty victim word by word, then gives its fetch beat. Each fill word is
//   decoded and written on its own; the last also runs tag update and finish.
//   Set rows and line words come from single-port RAMs with registered read.
//   A result waits in the output register while the next request is accepted;
//   when rsp stalls, the engine holds before its next beat.
//   Reset clears valid, dirty and age state at once (flip-flop flags), restores
//   write-back, write-allocate and LRU, and drops any pending miss.
`default_nettype none
module set_assoc_cache_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sacc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [0:0]                     cfg_data,
	sacc_req_if.sink                       req,
	sacc_rsp_if.source                     rsp
);
	import sacc_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign req.ready = ready;

	sacc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(ready),
		.sts(sts), .cmd(cmd));

	sacc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .cmd(cmd), .sts(sts));
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the set-associative cache controller.
// Needs sacc_pkg, sacc_ifs and the controller RTL; predicts every result beat in-bench.
`timescale 1ns / 100ps

module tb;
	import sacc_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] address;
		logic [1:0]  access_size;
		logic [31:0] write_data;
		logic [31:0] fill_data;
	} req_beat_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] address;
		logic [31:0] data;
		logic [1:0]  size;
		logic        hit;
		logic        last;
	} rsp_beat_t;

	typedef struct {
		logic        busy;
		logic        is_write;
		logic [31:0] address;
		logic [1:0]  size;
		logic [31:0] data;
		int          way;
	} miss_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [0:0] cfg_data = '0;

	sacc_req_if req ();
	sacc_rsp_if rsp ();

	set_assoc_cache_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #5 clk = ~clk;

	// cache image kept by the bench
	logic [TAG_W-1:0] line_tag [LINES];
	logic             line_valid [LINES];
	logic             line_dirty [LINES];
	logic [AGE_W-1:0] line_age [LINES];
	int               set_ptr [SETS];
	logic [31:0]      cache_words [DWORDS];
	miss_t            open_miss;
	int               fill_words;
	logic             wb_mode, alloc_mode, rr_mode;

	req_beat_t pending_beats[$];
	rsp_beat_t expected_rsp[$];
	int pushed_beats = 0;
	int accepted_beats = 0;
	int errors = 0;
	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic req_fired = 1'b0;

	function automatic logic [31:0] lane_bits(input logic [1:0] sz);
		case (sz)
			SZ_BYTE: return 32'h0000_00FF;
			SZ_HALF: return 32'h0000_FFFF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic void expect_beat(input kind_t k, input logic [31:0] a,
		input logic [31:0] d, input logic [1:0] sz, input logic hit);
		rsp_beat_t b;
		b.kind = k;
		b.address = a;
		b.data = d;
		b.size = sz;
		b.hit = hit;
		b.last = 1'b0;
		expected_rsp.push_back(b);
	endfunction

	function automatic void complete_access(input int set, input int way, input logic is_wr,
		input logic [31:0] a, input logic [1:0] sz, input logic [31:0] d, input logic hit);
		int line, wi, sh;
		logic [31:0] m, dm, cur;
		line = set * WAYS + way;
		wi = line * BLOCK_WORDS + int'(a[OFF_W-1:2]);
		sh = int'(a[1:0]) * 8;
		m = lane_bits(sz);
		dm = d & m;
		cur = (cache_words[wi] >> sh) & m;
		if (!is_wr) begin
			expect_beat(KIND_READ, a, cur, sz, hit);
		end else begin
			if (wb_mode)
				line_dirty[line] = 1'b1;
			else if (dm != cur)
				expect_beat(KIND_WTHRU, a, dm, sz, hit);
			cache_words[wi] = (cache_words[wi] & ~(m << sh)) | ((dm << sh) & (m << sh));
			expect_beat(KIND_WDONE, a, dm, sz, hit);
		end
		for (int t = 0; t < WAYS; t++)
			if (line_age[set * WAYS + t] != AGE_MAX)
				line_age[set * WAYS + t]++;
		line_age[line] = '0;
	endfunction

	// work out the result beats that one accepted request beat causes
	function automatic void predict_cache(input req_beat_t r);
		int n0, set, line, way, best;
		logic [1:0] sz;
		logic [31:0] a;
		logic [TAG_W-1:0] tg;
		logic hit;
		n0 = expected_rsp.size();
		hit = 1'b0;
		way = 0;
		if (r.op == OP_FILL) begin
			if (open_miss.busy) begin
				set = int'(open_miss.address[OFF_W +: SET_W]);
				line = set * WAYS + open_miss.way;
				cache_words[line * BLOCK_WORDS + fill_words] = r.fill_data;
				fill_words++;
				if (fill_words == BLOCK_WORDS) begin
					fill_words = 0;
					line_tag[line] = open_miss.address[31 -: TAG_W];
					line_valid[line] = 1'b1;
					line_dirty[line] = 1'b0;
					open_miss.busy = 1'b0;
					complete_access(set, open_miss.way, open_miss.is_write,
						open_miss.address, open_miss.size, open_miss.data, 1'b0);
				end
			end
		end else if (r.op != OP_NONE) begin
			if (open_miss.busy) begin
				expect_beat(KIND_BUSY, '0, '0, SZ_BYTE, 1'b0);
			end else begin
				sz = (r.access_size > SZ_WORD) ? SZ_WORD : r.access_size;
				a = r.address;
				if (sz == SZ_WORD) a[1:0] = 2'b00;
				else if (sz == SZ_HALF) a[0] = 1'b0;
				set = int'(a[OFF_W +: SET_W]);
				tg = a[31 -: TAG_W];
				for (int t = 0; t < WAYS; t++)
					if (line_valid[set * WAYS + t] && line_tag[set * WAYS + t] == tg) begin
						hit = 1'b1;
						way = t;
					end
				if (hit) begin
					complete_access(set, way, r.op == OP_WRITE, a, sz, r.write_data, 1'b1);
				end else if (r.op == OP_WRITE && !alloc_mode) begin
					expect_beat(KIND_WTHRU, a, r.write_data & lane_bits(sz), sz, 1'b0);
					expect_beat(KIND_WDONE, a, r.write_data & lane_bits(sz), sz, 1'b0);
				end else begin
					way = set_ptr[set];
					if (!rr_mode) begin
						best = 0;
						for (int t = 0; t < WAYS; t++)
							if (int'(line_age[set * WAYS + t]) > best) begin
								best = int'(line_age[set * WAYS + t]);
								way = t;
							end
					end else begin
						way++;
					end
					if (way >= WAYS) way = 0;
					set_ptr[set] = way;
					line = set * WAYS + way;
					if (wb_mode && line_valid[line] && line_dirty[line]) begin
						for (int t = 0; t < BLOCK_WORDS; t++)
							expect_beat(KIND_WBACK,
								{line_tag[line], set[SET_W-1:0], {OFF_W{1'b0}}} + 32'(4 * t),
								cache_words[line * BLOCK_WORDS + t], SZ_WORD, 1'b0);
						line_dirty[line] = 1'b0;
					end
					expect_beat(KIND_FETCH, {a[31:OFF_W], {OFF_W{1'b0}}}, '0, SZ_BYTE, 1'b0);
					open_miss.busy = 1'b1;
					open_miss.is_write = (r.op == OP_WRITE);
					open_miss.address = a;
					open_miss.size = sz;
					open_miss.data = r.write_data;
					open_miss.way = way;
					fill_words = 0;
				end
			end
		end
		if (expected_rsp.size() > n0)
			expected_rsp[expected_rsp.size() - 1].last = 1'b1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	// monitor: predict on request beats, compare result beats, watch for a hang
	always @(posedge clk) begin
		rsp_beat_t e;
		req_beat_t r;
		if (arst_n) begin
			req_fired <= req.valid && req.ready;
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report("result beat with nothing expected", {29'd0, rsp.kind}, '0);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.kind != e.kind) report("kind", {29'd0, rsp.kind}, {29'd0, e.kind});
					if (rsp.out_address != e.address) report("out_address", rsp.out_address, e.address);
					if (rsp.out_data != e.data) report("out_data", rsp.out_data, e.data);
					if (rsp.out_size != e.size) report("out_size", {30'd0, rsp.out_size}, {30'd0, e.size});
					if (rsp.was_hit != e.hit) report("was_hit", {31'd0, rsp.was_hit}, {31'd0, e.hit});
					if (rsp.last != e.last) report("last", {31'd0, rsp.last}, {31'd0, e.last});
				end
			end
			if (req.valid && req.ready) begin
				r.op = req.op;
				r.address = req.address;
				r.access_size = req.access_size;
				r.write_data = req.write_data;
				r.fill_data = req.fill_data;
				predict_cache(r);
				accepted_beats++;
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
				(pending_beats.size() == 0 && expected_rsp.size() == 0 &&
				accepted_beats == pushed_beats))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// request driver: hold the beat until taken, idle at random between beats
	always @(negedge clk) begin
		req_beat_t b;
		if (arst_n && (!req.valid || req_fired)) begin
			if (pending_beats.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				b = pending_beats.pop_front();
				req.valid <= 1'b1;
				req.op <= b.op;
				req.address <= b.address;
				req.access_size <= b.access_size;
				req.write_data <= b.write_data;
				req.fill_data <= b.fill_data;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	task automatic push_beat(input logic [1:0] op, input logic [31:0] a, input logic [1:0] sz,
		input logic [31:0] wd);
		req_beat_t b;
		b.op = op;
		b.address = a;
		b.access_size = sz;
		b.write_data = wd;
		b.fill_data = $urandom;
		pending_beats.push_back(b);
		pushed_beats++;
	endtask

	// complete any open miss with a block of fill beats, optionally after one busy-rejected request
	task automatic serve_miss(input logic add_busy);
		wait (accepted_beats == pushed_beats);
		if (open_miss.busy) begin
			if (add_busy)
				push_beat(2'($urandom_range(1)), $urandom, 2'($urandom_range(3)), $urandom);
			for (int i = 0; i < BLOCK_WORDS; i++)
				push_beat(OP_FILL, $urandom, 2'($urandom_range(3)), $urandom);
		end
	endtask

	task automatic access(input logic [1:0] op, input logic [31:0] a, input logic [1:0] sz,
		input logic [31:0] wd, input logic add_busy);
		push_beat(op, a, sz, wd);
		serve_miss(add_busy);
	endtask

	// few tags over few sets, so hits, evictions and dirty victims are common
	function automatic logic [31:0] pick_address();
		logic [TAG_W-1:0] tg;
		logic [SET_W-1:0] st;
		if ($urandom_range(15) == 0) return $urandom;
		case ($urandom_range(7))
			6: tg = '1;
			7: tg = TAG_W'($urandom);
			default: tg = TAG_W'($urandom_range(5));
		endcase
		st = ($urandom_range(7) == 0) ? SET_W'($urandom) : SET_W'($urandom_range(3));
		return {tg, st, OFF_W'($urandom)};
	endfunction

	task automatic random_access(input logic burst);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			push_beat(OP_NONE, $urandom, 2'($urandom_range(3)), $urandom);
		else if (r < 8)
			push_beat(OP_FILL, $urandom, 2'($urandom_range(3)), $urandom);
		else if (burst)
			push_beat(2'($urandom_range(1)), pick_address(), 2'($urandom_range(3)), $urandom);
		else
			access(2'($urandom_range(1)), pick_address(), 2'($urandom_range(3)), $urandom, r < 14);
	endtask

	task automatic settle();
		wait (accepted_beats == pushed_beats && expected_rsp.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic wb, input logic alloc, input logic repl);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_WB_MODE;
		cfg_data = wb;
		@(negedge clk);
		cfg_index = REG_WR_ALLOC;
		cfg_data = alloc;
		@(negedge clk);
		cfg_index = REG_REPL;
		cfg_data = repl;
		@(negedge clk);
		cfg_we = 1'b0;
		wb_mode = wb;
		alloc_mode = alloc;
		rr_mode = repl;
	endtask

	task automatic run_phase(input int idx, input logic wb, input logic alloc, input logic repl,
		input int idle, input int stall, input int beats);
		int start;
		settle();
		write_regs(wb, alloc, repl);
		src_idle_pct = idle;
		rcv_stall_pct = stall;
		start = pushed_beats;
		if (idx == 1) begin
			// write around, then allocate, then rewrite with changed and then equal data
			access(OP_WRITE, 32'h0000_0040, SZ_WORD, 32'h1234_5678, 1'b0);
			access(OP_READ, 32'h0000_0040, SZ_WORD, '0, 1'b0);
			access(OP_WRITE, 32'h0000_0042, SZ_HALF, 32'hFFFF_A5A5, 1'b0);
			access(OP_WRITE, 32'h0000_0042, SZ_HALF, 32'h0000_A5A5, 1'b0);
		end
		if (idx == 2) begin
			// hold the receiver while requests keep coming, so the input backs up
			@(posedge clk);
			hold_left = 400;
			for (int i = 0; i < 12; i++) random_access(1'b1);
			serve_miss(1'b0);
		end
		while (pushed_beats - start < beats) begin
			random_access(1'b0);
			if (idx == 3 && pushed_beats - start > beats / 2 && pushed_beats - start < beats / 2 + 10)
				wait (accepted_beats == pushed_beats && expected_rsp.size() == 0);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.op = OP_NONE;
		req.address = '0;
		req.access_size = SZ_BYTE;
		req.write_data = '0;
		req.fill_data = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_dirty[i] = 1'b0;
			line_age[i] = '0;
			line_tag[i] = '0;
		end
		for (int i = 0; i < SETS; i++) set_ptr[i] = 0;
		for (int i = 0; i < DWORDS; i++) cache_words[i] = '0;
		open_miss = '{busy: 1'b0, is_write: 1'b0, address: '0, size: '0, data: '0, way: 0};
		fill_words = 0;
		wb_mode = 1'b1;
		alloc_mode = 1'b1;
		rr_mode = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ignored op, stray fill, miss and hits of each size, busy reject
		push_beat(OP_NONE, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
		push_beat(OP_FILL, '0, SZ_BYTE, '0);
		access(OP_READ, 32'h0000_0000, SZ_WORD, '0, 1'b0);
		access(OP_WRITE, 32'h0000_0003, SZ_BYTE, 32'hFFFF_FFAB, 1'b0);
		access(OP_WRITE, 32'h0000_0005, SZ_HALF, 32'h0000_BEEF, 1'b0);
		access(OP_WRITE, 32'h0000_001E, 2'd3, 32'hFFFF_FFFF, 1'b0);
		access(OP_READ, 32'h0000_0003, SZ_BYTE, '0, 1'b0);
		access(OP_WRITE, 32'hFFFF_FFFF, SZ_BYTE, 32'h0000_0000, 1'b1);

		run_phase(1, 1'b0, 1'b0, 1'b1, 67, 0, 58);
		run_phase(2, 1'b1, 1'b0, 1'b0, 0, 67, 58);
		run_phase(3, 1'b0, 1'b1, 1'b1, 35, 35, 58);
		run_phase(4, 1'b1, 1'b1, 1'b1, 0, 0, 58);
		settle();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+src
src/sacc_pkg.sv
src/sacc_ifs.sv
src/sacc_ram.sv
src/sacc_datapath.sv
src/sacc_ctrl.sv
src/set_assoc_cache_controller.sv
bench/tb.sv
